@@ sv/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrs_pkg: shared types and constants of the periodic task release scheduler
// Holds the command codes of an input beat, the sequencer states and the
// fixed widths of the payload fields.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  // Command carried by an input beat.
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROC  = 2'd1,
    ST_FLUSH = 2'd2
  } state_e;

  localparam int unsigned TASK_ID_W   = 3;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned TASK_CNT_W  = 4;
  localparam int unsigned RESULT_LIMIT = 8;
  localparam int unsigned REL_CNT_W   = 4;

endpackage

@@ sv/periodic_task_release_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler: time-triggered task release scheduler
// Keeps per-slot countdowns and reload periods in small memories and walks
// the active slots one per cycle, unless a stalled output holds the walk, on start and tick beats, releasing tasks.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (task_count)
//  in      | in        | in_valid_i / in_ready_o   | kind, slot_index, delays
//  out     | out       | out_valid_o / out_ready_i | released_task, tick_value, last
//
//  Load and stop beats do not start a walk. Start and tick beats (a tick
//  only while running) walk N slots, where N is min(task_count, MAX_TASKS):
//  acceptance issues the first memory read, the shared decrement and
//  compare unit then takes one slot per cycle unless a stalled output holds
//  the walk, and the flush state hands over the last release. The single
//  read port of the countdown memory limits the walk to one slot per cycle.
//  Reset clears the run flag, the tick count, the ready marks and the
//  sequencer; the countdown and period memories are not cleared and hold
//  whatever the load beats wrote. A stalled output stalls the slot walk only
//  when a new release finds both the output register and the pending
//  release register occupied.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler #(
  parameter int MAX_TASKS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ptrs_pkg::TASK_CNT_W-1:0]       cfg_data_i,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            kind_i,
  input  logic [ptrs_pkg::TASK_ID_W-1:0]        slot_index_i,
  input  logic [ptrs_pkg::FIELD_W-1:0]          first_delay_i,
  input  logic [ptrs_pkg::FIELD_W-1:0]          reload_period_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [ptrs_pkg::TASK_ID_W-1:0]        released_task_o,
  output logic [ptrs_pkg::TICK_W-1:0]           tick_value_o,
  output logic                                  last_release_o
);

  // Slot index width and a scan counter wide enough to hold MAX_TASKS.
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // Countdown and period memories: one write and one registered read port.
  logic [COUNT_BITS-1:0] cd_mem [MAX_TASKS];
  logic [COUNT_BITS-1:0] pr_mem [MAX_TASKS];
  logic [COUNT_BITS-1:0] cd_rd_q;
  logic [COUNT_BITS-1:0] pr_rd_q;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  cd_we;
  logic [IDX_W-1:0]      cd_waddr;
  logic [COUNT_BITS-1:0] cd_wdata;
  logic                  pr_we;

  // Control and status state.
  ptrs_pkg::state_e                   state_q, state_d;
  logic                               running_q, running_d;
  logic [ptrs_pkg::TICK_W-1:0]        tick_q, tick_d;
  logic [ptrs_pkg::TASK_CNT_W-1:0]    task_cnt_q;
  logic [MAX_TASKS-1:0]               ready_q, ready_d;
  logic                               mode_tick_q, mode_tick_d;
  logic [CNT_W-1:0]                   proc_q, proc_d;
  logic [ptrs_pkg::REL_CNT_W-1:0]     n_q, n_d;
  logic                               pend_valid_q, pend_valid_d;
  logic [ptrs_pkg::TASK_ID_W-1:0]     pend_task_q, pend_task_d;

  // Output register.
  logic                               out_valid_q, out_valid_d;
  logic [ptrs_pkg::TASK_ID_W-1:0]     out_task_q, out_task_d;
  logic [ptrs_pkg::TICK_W-1:0]        out_tick_q, out_tick_d;
  logic                               out_last_q, out_last_d;

  // Datapath of the slot walk.
  logic [CNT_W-1:0]      lim;
  logic [CNT_W-1:0]      proc_next;
  logic [IDX_W-1:0]      proc_idx;
  logic [IDX_W-1:0]      slot_idx;
  logic                  slot_ok;
  logic [COUNT_BITS-1:0] load_delay;
  logic [COUNT_BITS-1:0] load_period;
  logic [COUNT_BITS-1:0] cd_dec;
  logic [COUNT_BITS-1:0] cd_upd;
  logic                  fire;
  logic                  rel;
  logic                  out_free;
  logic                  start_scan;

  assign cfg_ready_o = 1'b1;

  // Number of slots visited: task_count, capped at the table size.
  assign lim = (32'(task_cnt_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_cnt_q);

  assign proc_next   = proc_q + CNT_W'(1);
  assign proc_idx    = proc_q[IDX_W-1:0];
  assign slot_idx    = IDX_W'(slot_index_i);
  assign slot_ok     = 32'(slot_index_i) < MAX_TASKS;
  assign load_delay  = COUNT_BITS'(first_delay_i);
  assign load_period = COUNT_BITS'(reload_period_i);

  // Shared unit: one decrement and zero compare per visited slot. On a start
  // walk the countdown passes through unchanged and only ready marks fire.
  assign cd_dec   = cd_rd_q - COUNT_BITS'(1);
  assign cd_upd   = mode_tick_q ? cd_dec : cd_rd_q;
  assign fire     = ready_q[proc_idx] | (mode_tick_q && (cd_dec == '0));
  assign rel      = fire && (n_q < ptrs_pkg::REL_CNT_W'(ptrs_pkg::RESULT_LIMIT));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    tick_d       = tick_q;
    ready_d      = ready_q;
    mode_tick_d  = mode_tick_q;
    proc_d       = proc_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_task_d  = pend_task_q;
    out_valid_d  = out_valid_q;
    out_task_d   = out_task_q;
    out_tick_d   = out_tick_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_addr      = proc_idx;
    cd_we        = 1'b0;
    cd_waddr     = proc_idx;
    cd_wdata     = cd_upd;
    pr_we        = 1'b0;
    start_scan   = 1'b0;
    in_ready_o   = (state_q == ptrs_pkg::ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ptrs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (ptrs_pkg::kind_e'(kind_i))
            ptrs_pkg::KIND_LOAD: begin
              if (!running_q && slot_ok) begin
                cd_we             = 1'b1;
                cd_waddr          = slot_idx;
                cd_wdata          = load_delay;
                pr_we             = 1'b1;
                ready_d[slot_idx] = (load_delay == '0);
              end
            end
            ptrs_pkg::KIND_START: begin
              running_d   = 1'b1;
              mode_tick_d = 1'b0;
              start_scan  = 1'b1;
            end
            ptrs_pkg::KIND_TICK: begin
              if (running_q) begin
                tick_d      = tick_q + ptrs_pkg::TICK_W'(1);
                mode_tick_d = 1'b1;
                start_scan  = 1'b1;
              end
            end
            ptrs_pkg::KIND_STOP: begin
              running_d = 1'b0;
            end
          endcase
          if (start_scan && (lim != '0)) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            proc_d  = '0;
            n_d     = '0;
            state_d = ptrs_pkg::ST_PROC;
          end
        end
      end

      ptrs_pkg::ST_PROC: begin
        // A new release needs room: the pending one moves to the output.
        if (!rel || !pend_valid_q || out_free) begin
          if (mode_tick_q || rel) begin
            cd_we    = 1'b1;
            cd_wdata = rel ? pr_rd_q : cd_upd;
          end
          ready_d[proc_idx] = fire && !rel;
          if (rel) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_task_d  = pend_task_q;
              out_tick_d  = tick_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_task_d  = ptrs_pkg::TASK_ID_W'(proc_idx);
            n_d          = n_q + ptrs_pkg::REL_CNT_W'(1);
          end
          if (proc_next < lim) begin
            rd_en   = 1'b1;
            rd_addr = proc_next[IDX_W-1:0];
            proc_d  = proc_next;
          end else begin
            state_d = ptrs_pkg::ST_FLUSH;
          end
        end
      end

      ptrs_pkg::ST_FLUSH: begin
        // The release still pending is the last one of this beat.
        if (!pend_valid_q) begin
          state_d = ptrs_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_task_d   = pend_task_q;
          out_tick_d   = tick_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ptrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptrs_pkg::ST_IDLE;
      running_q    <= 1'b0;
      tick_q       <= '0;
      task_cnt_q   <= '0;
      ready_q      <= '0;
      mode_tick_q  <= 1'b0;
      proc_q       <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      tick_q       <= tick_d;
      ready_q      <= ready_d;
      mode_tick_q  <= mode_tick_d;
      proc_q       <= proc_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        task_cnt_q <= cfg_data_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    pend_task_q <= pend_task_d;
    out_task_q  <= out_task_d;
    out_tick_q  <= out_tick_d;
    out_last_q  <= out_last_d;
  end

  // Slot memories.
  always_ff @(posedge clk_i) begin
    if (cd_we) begin
      cd_mem[cd_waddr] <= cd_wdata;
    end
    if (pr_we) begin
      pr_mem[slot_idx] <= load_period;
    end
    if (rd_en) begin
      cd_rd_q <= cd_mem[rd_addr];
      pr_rd_q <= pr_mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign released_task_o = out_task_q;
  assign tick_value_o    = out_tick_q;
  assign last_release_o  = out_last_q;

  // No beat ever produces more releases than the result limit.
  a_rel_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ptrs_pkg::REL_CNT_W'(ptrs_pkg::RESULT_LIMIT))
    else $error("release count above limit");

  // Back in idle, no release may be left pending.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptrs_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("pending release lost on return to idle");

  // The walk never visits a slot beyond the scan limit.
  a_proc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptrs_pkg::ST_PROC) |-> (proc_q < lim))
    else $error("slot walk beyond scan limit");

  // An accepted tick while running advances the tick count by one.
  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == ptrs_pkg::KIND_TICK) && running_q)
    |=> (tick_q == $past(tick_q) + ptrs_pkg::TICK_W'(1)))
    else $error("tick count did not advance");

  // The tick count is frozen during a slot walk.
  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ptrs_pkg::ST_IDLE) |=> $stable(tick_q))
    else $error("tick count changed during a walk");

endmodule
